// ===== hdl/vbjs_pkg.sv =====
// Package for the accelerator job scheduler.
// Holds op, status, cfg index and controller state codes plus shared structs.
// No dependencies.
package vbjs_pkg;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_START   = 2'd1,
    OP_DONE    = 2'd2,
    OP_FAIL    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_STARTED  = 3'd1,
    ST_NONE     = 3'd2,
    ST_QFULL    = 3'd3,
    ST_BUSY     = 3'd4,
    ST_NOFREE   = 3'd5,
    ST_TFULL    = 3'd6,
    ST_BADDONE  = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    REG_TOTAL   = 3'd0,
    REG_CACHE   = 3'd1,
    REG_GEN     = 3'd2,
    REG_PREVIEW = 3'd3,
    REG_RESERVE = 3'd4
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_PICK,
    S_LOOKUP,
    S_EVICT,
    S_PLACE,
    S_COMMIT,
    S_FINISH,
    S_COUNT,
    S_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture input item
    logic enqueue;    // perform enqueue
    logic scan_clr;   // reset scan index and best
    logic scan_step;  // evaluate one queue entry
    logic lookup;     // model lookup for chosen entry
    logic evict;      // evict one LRU model
    logic place;      // place model, slot reuse
    logic hit_commit; // commit start on cache hit
    logic commit;     // reserve pool, mark running
    logic finish;     // release active job
    logic cnt_clr;    // model count reset, unused by the datapath
    logic cnt_step;   // count one model slot
    logic set_status; // latch status code
    status_e status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic busy;       // a job is active
    logic scan_last;  // last queue entry being scanned
    logic best_found;
    logic hit;
    logic fits;       // model fits cache
    logic lru_found;
    logic free_found;
    logic cnt_last;
  } stat_t;

endpackage

// ===== hdl/vbjs_ctrl.sv =====
// Controller state machine of the job scheduler.
// Depends on vbjs_pkg.
module vbjs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  vbjs_pkg::stat_t stat_i,
  output vbjs_pkg::cmd_t  cmd_o
);

  vbjs_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vbjs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.status = vbjs_pkg::ST_OK;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      vbjs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = vbjs_pkg::S_DECODE;
        end
      end
      vbjs_pkg::S_DECODE: begin
        unique case (stat_i.op)
          vbjs_pkg::OP_ENQUEUE: begin
            cmd_o.enqueue = 1'b1;
            state_d = vbjs_pkg::S_COUNT;
          end
          vbjs_pkg::OP_START: begin
            if (stat_i.busy) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status = vbjs_pkg::ST_BUSY;
              state_d = vbjs_pkg::S_COUNT;
            end else begin
              cmd_o.scan_clr = 1'b1;
              state_d = vbjs_pkg::S_SCAN;
            end
          end
          default: begin
            cmd_o.finish = 1'b1;
            state_d = vbjs_pkg::S_COUNT;
          end
        endcase
      end
      vbjs_pkg::S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) state_d = vbjs_pkg::S_PICK;
      end
      vbjs_pkg::S_PICK: begin
        if (!stat_i.best_found) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status = vbjs_pkg::ST_NONE;
          state_d = vbjs_pkg::S_COUNT;
        end else begin
          cmd_o.lookup = 1'b1;
          state_d = vbjs_pkg::S_LOOKUP;
        end
      end
      vbjs_pkg::S_LOOKUP: begin
        if (stat_i.hit) begin
          cmd_o.hit_commit = 1'b1;
          state_d = vbjs_pkg::S_COMMIT;
        end else begin
          state_d = vbjs_pkg::S_EVICT;
        end
      end
      vbjs_pkg::S_EVICT: begin
        if (stat_i.fits) begin
          state_d = vbjs_pkg::S_PLACE;
        end else if (stat_i.lru_found) begin
          cmd_o.evict = 1'b1;
        end else begin
          cmd_o.set_status = 1'b1;
          cmd_o.status = vbjs_pkg::ST_NOFREE;
          state_d = vbjs_pkg::S_COUNT;
        end
      end
      vbjs_pkg::S_PLACE: begin
        if (stat_i.free_found || stat_i.lru_found) begin
          cmd_o.place = 1'b1;
          state_d = vbjs_pkg::S_COMMIT;
        end else begin
          cmd_o.set_status = 1'b1;
          cmd_o.status = vbjs_pkg::ST_TFULL;
          state_d = vbjs_pkg::S_COUNT;
        end
      end
      vbjs_pkg::S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = vbjs_pkg::S_COUNT;
      end
      vbjs_pkg::S_FINISH: begin
        state_d = vbjs_pkg::S_COUNT;
      end
      vbjs_pkg::S_COUNT: begin
        cmd_o.cnt_step = 1'b1;
        if (stat_i.cnt_last) state_d = vbjs_pkg::S_OUT;
      end
      vbjs_pkg::S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.cnt_clr = 1'b1;
          state_d = vbjs_pkg::S_IDLE;
        end
      end
      default: state_d = vbjs_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== hdl/vbjs_dp.sv =====
// Datapath of the job scheduler: queue table, residency table, pool counters.
// Depends on vbjs_pkg.
module vbjs_dp #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned MODEL_SLOTS = 8,
  parameter int unsigned KEY_BITS    = 16,
  parameter int unsigned SPACE_BITS  = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  vbjs_pkg::cmd_t        cmd_i,
  output vbjs_pkg::stat_t       stat_o,
  input  logic [1:0]            op_i,
  input  logic [1:0]            prio_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [SPACE_BITS-1:0] msize_i,
  input  logic [SPACE_BITS-1:0] jsize_i,
  input  logic [SPACE_BITS-1:0] psize_i,
  input  logic [31:0]           tag_i,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [SPACE_BITS-1:0] cfg_data_i,
  output logic [2:0]            status_o,
  output logic [31:0]           job_o,
  output logic [1:0]            prio_o,
  output logic                  hit_o,
  output logic [4:0]            pos_o,
  output logic [SPACE_BITS-1:0] free_o,
  output logic [3:0]            count_o
);

  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned MW = (MODEL_SLOTS > 1) ? $clog2(MODEL_SLOTS) : 1;
  localparam int unsigned QC = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MC = $clog2(MODEL_SLOTS + 1);
  localparam int unsigned SW = SPACE_BITS + 3;
  localparam logic [4:0]  RefsMax = 5'd31;

  // Configuration registers.
  logic [SPACE_BITS-1:0] total_q, cache_q, gen_q, prev_q, resv_q;

  // Captured item.
  logic [1:0]            op_q, iprio_q;
  logic [KEY_BITS-1:0]   ikey_q;
  logic [SPACE_BITS-1:0] imsz_q, ijsz_q, ipsz_q;
  logic [31:0]           tag_q;

  // Queue table.
  logic [QUEUE_DEPTH-1:0] sused_q, srun_q;
  logic [31:0]            sid_q [QUEUE_DEPTH];
  logic [1:0]             sprio_q [QUEUE_DEPTH];
  logic [31:0]            sage_q [QUEUE_DEPTH];
  logic [KEY_BITS-1:0]    skey_q [QUEUE_DEPTH];
  logic [SPACE_BITS-1:0]  smsz_q [QUEUE_DEPTH];
  logic [SPACE_BITS-1:0]  sjsz_q [QUEUE_DEPTH];
  logic [SPACE_BITS-1:0]  spsz_q [QUEUE_DEPTH];

  // Residency table.
  logic [MODEL_SLOTS-1:0] mused_q;
  logic [KEY_BITS-1:0]    mkey_q [MODEL_SLOTS];
  logic [SPACE_BITS-1:0]  mbytes_q [MODEL_SLOTS];
  logic [4:0]             mrefs_q [MODEL_SLOTS];
  logic [31:0]            mlast_q [MODEL_SLOTS];

  // Scalar state.
  logic [31:0]           tick_q, next_id_q, active_id_q;
  logic                  active_ok_q;
  logic [QW-1:0]         active_slot_q;
  logic [QC-1:0]         waiting_q;
  logic [SPACE_BITS-1:0] rmodel_q, rjob_q, rprev_q;

  // Scan and result registers.
  logic [QW-1:0]         scan_q;
  logic                  best_ok_q;
  logic [QW-1:0]         best_q;
  logic                  hitf_q;
  logic [MW-1:0]         hit_idx_q;
  logic [MW-1:0]         cnt_idx_q;
  logic [MC-1:0]         cnt_q;
  logic [2:0]            status_q;
  logic [31:0]           job_q;
  logic [1:0]            oprio_q;
  logic                  ohit_q;
  logic [4:0]            pos_q;

  // Model lookup by key.
  function automatic logic [MW:0] find_key(
    input logic [KEY_BITS-1:0] key, input logic [MODEL_SLOTS-1:0] used,
    input logic [KEY_BITS-1:0] keys [MODEL_SLOTS]);
    logic [MW:0] r;
    r = '0;
    for (int i = MODEL_SLOTS - 1; i >= 0; i--) begin
      if (used[i] && keys[i] == key) r = {1'b1, MW'(i)};
    end
    return r;
  endfunction

  // First free queue entry.
  logic          qfree_ok;
  logic [QW-1:0] qfree;
  always_comb begin
    qfree_ok = 1'b0;
    qfree    = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!sused_q[i]) begin
        qfree_ok = 1'b1;
        qfree    = QW'(i);
      end
    end
  end

  // First free model slot and LRU unreferenced model.
  logic          mfree_ok, lru_ok;
  logic [MW-1:0] mfree, lru;
  always_comb begin
    mfree_ok = 1'b0;
    mfree    = '0;
    lru_ok   = 1'b0;
    lru      = '0;
    for (int i = 0; i < MODEL_SLOTS; i++) begin
      if (!mused_q[i] && !mfree_ok) begin
        mfree_ok = 1'b1;
        mfree    = MW'(i);
      end
      if (mused_q[i] && mrefs_q[i] == 5'd0 &&
          (!lru_ok || mlast_q[i] < mlast_q[lru])) begin
        lru_ok = 1'b1;
        lru    = MW'(i);
      end
    end
  end

  // Runnable check for the scanned entry.
  logic [QW-1:0] sidx;
  logic [MW:0]   sfind;
  logic          runnable, better;
  logic [SW-1:0] pm, pj, pp, tot;
  assign sidx  = scan_q;
  assign sfind = find_key(skey_q[sidx], mused_q, mkey_q);
  always_comb begin
    runnable = 1'b1;
    pm = SW'(rmodel_q);
    pj = SW'(rjob_q);
    pp = SW'(rprev_q);
    if (!sfind[MW]) begin
      if (smsz_q[sidx] > cache_q) runnable = 1'b0;
      if (pm + SW'(smsz_q[sidx]) <= SW'(cache_q)) pm = pm + SW'(smsz_q[sidx]);
    end
    if (sprio_q[sidx] == 2'd0) begin
      if (pp + SW'(spsz_q[sidx]) > SW'(prev_q)) runnable = 1'b0;
      pp = pp + SW'(spsz_q[sidx]);
    end else begin
      if (pj + SW'(sjsz_q[sidx]) > SW'(gen_q)) runnable = 1'b0;
      pj = pj + SW'(sjsz_q[sidx]);
    end
    tot = pm + pj + pp + SW'(resv_q);
    if (tot > SW'(total_q)) runnable = 1'b0;
    runnable = runnable && sused_q[sidx] && !srun_q[sidx];
    better = !best_ok_q || sprio_q[sidx] < sprio_q[best_q] ||
             (sprio_q[sidx] == sprio_q[best_q] && sage_q[sidx] < sage_q[best_q]);
  end

  // Model lookup and fit check for the chosen entry.
  logic [MW:0] bfind;
  logic        fits;
  assign bfind = find_key(skey_q[best_q], mused_q, mkey_q);
  assign fits  = (SW'(rmodel_q) + SW'(smsz_q[best_q])) <= SW'(cache_q);

  // Finish checks.
  logic [MW:0] ffind;
  logic        fin_ok;
  assign ffind  = find_key(skey_q[active_slot_q], mused_q, mkey_q);
  assign fin_ok = active_id_q != 32'd0 && tag_q == active_id_q && active_ok_q &&
                  sused_q[active_slot_q] && sid_q[active_slot_q] == tag_q;

  // Replacement target and ticks.
  logic [MW-1:0] place_idx;
  logic [31:0]   tick_inc, nid_inc;
  assign place_idx = mfree_ok ? mfree : lru;
  assign tick_inc  = tick_q + 32'd1;
  assign nid_inc   = (next_id_q == 32'hFFFF_FFFF) ? 32'd1 : next_id_q + 32'd1;

  // Free space after the step.
  logic [SW-1:0] used_sum;
  assign used_sum = SW'(rmodel_q) + SW'(rjob_q) + SW'(rprev_q) + SW'(resv_q);
  assign free_o   = (SW'(total_q) > used_sum) ?
                    SPACE_BITS'(SW'(total_q) - used_sum) : '0;

  // Status to controller.
  always_comb begin
    stat_o            = '0;
    stat_o.op         = vbjs_pkg::op_e'(op_q);
    stat_o.busy       = active_id_q != 32'd0 || active_ok_q;
    stat_o.scan_last  = scan_q == QW'(QUEUE_DEPTH - 1);
    stat_o.best_found = best_ok_q;
    stat_o.hit        = hitf_q;
    stat_o.fits       = fits;
    stat_o.lru_found  = lru_ok;
    stat_o.free_found = mfree_ok;
    stat_o.cnt_last   = cnt_idx_q == MW'(MODEL_SLOTS - 1);
  end

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0; cache_q <= '0; gen_q <= '0; prev_q <= '0; resv_q <= '0;
      sused_q <= '0; srun_q <= '0; mused_q <= '0;
      tick_q <= '0; next_id_q <= 32'd1; active_id_q <= '0;
      active_ok_q <= 1'b0; waiting_q <= '0;
      rmodel_q <= '0; rjob_q <= '0; rprev_q <= '0;
      best_ok_q <= 1'b0; scan_q <= '0; cnt_idx_q <= '0; cnt_q <= '0;
      hitf_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          vbjs_pkg::REG_TOTAL:   total_q <= cfg_data_i;
          vbjs_pkg::REG_CACHE:   cache_q <= cfg_data_i;
          vbjs_pkg::REG_GEN:     gen_q   <= cfg_data_i;
          vbjs_pkg::REG_PREVIEW: prev_q  <= cfg_data_i;
          vbjs_pkg::REG_RESERVE: resv_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.enqueue && qfree_ok) begin
        sused_q[qfree] <= 1'b1;
        srun_q[qfree]  <= 1'b0;
        next_id_q      <= nid_inc;
        tick_q         <= tick_inc;
        waiting_q      <= waiting_q + QC'(1);
      end
      if (cmd_i.scan_clr) begin
        scan_q    <= '0;
        best_ok_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        scan_q <= scan_q + QW'(1);
        if (runnable && better) best_ok_q <= 1'b1;
      end
      if (cmd_i.lookup) hitf_q <= bfind[MW];
      if (cmd_i.hit_commit) tick_q <= tick_inc;
      if (cmd_i.evict) begin
        rmodel_q     <= (rmodel_q >= mbytes_q[lru]) ? rmodel_q - mbytes_q[lru] : '0;
        mused_q[lru] <= 1'b0;
      end
      if (cmd_i.place) begin
        mused_q[place_idx] <= 1'b1;
        tick_q <= tick_inc;
        rmodel_q <= SPACE_BITS'((mfree_ok ? rmodel_q :
                    ((rmodel_q >= mbytes_q[lru]) ? rmodel_q - mbytes_q[lru] : '0))
                    + smsz_q[best_q]);
      end
      if (cmd_i.commit) begin
        if (sprio_q[best_q] == 2'd0) rprev_q <= rprev_q + spsz_q[best_q];
        else rjob_q <= rjob_q + sjsz_q[best_q];
        srun_q[best_q] <= 1'b1;
        active_id_q    <= sid_q[best_q];
        active_ok_q    <= 1'b1;
        if (waiting_q != '0) waiting_q <= waiting_q - QC'(1);
      end
      if (cmd_i.finish && fin_ok) begin
        if (sprio_q[active_slot_q] == 2'd0) begin
          if (rprev_q >= spsz_q[active_slot_q]) rprev_q <= rprev_q - spsz_q[active_slot_q];
        end else begin
          if (rjob_q >= sjsz_q[active_slot_q]) rjob_q <= rjob_q - sjsz_q[active_slot_q];
        end
        if (ffind[MW] && mrefs_q[ffind[MW-1:0]] != 5'd0) tick_q <= tick_inc;
        sused_q[active_slot_q] <= 1'b0;
        srun_q[active_slot_q]  <= 1'b0;
        active_id_q <= '0;
        active_ok_q <= 1'b0;
      end
      if (cmd_i.cnt_step) begin
        cnt_idx_q <= stat_o.cnt_last ? '0 : cnt_idx_q + MW'(1);
        cnt_q     <= (cnt_idx_q == '0 ? MC'(0) : cnt_q) +
                     MC'(mused_q[cnt_idx_q]);
      end
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i; iprio_q <= prio_i; ikey_q <= key_i;
      imsz_q <= msize_i; ijsz_q <= jsize_i; ipsz_q <= psize_i; tag_q <= tag_i;
      status_q <= vbjs_pkg::ST_OK; job_q <= '0; oprio_q <= '0;
      ohit_q <= 1'b0; pos_q <= '0;
    end
    if (cmd_i.set_status) status_q <= cmd_i.status;
    if (cmd_i.enqueue) begin
      if (qfree_ok) begin
        sid_q[qfree]   <= next_id_q;
        sprio_q[qfree] <= iprio_q;
        sage_q[qfree]  <= tick_inc;
        skey_q[qfree]  <= ikey_q;
        smsz_q[qfree]  <= imsz_q;
        sjsz_q[qfree]  <= ijsz_q;
        spsz_q[qfree]  <= ipsz_q;
        job_q   <= next_id_q;
        oprio_q <= iprio_q;
        pos_q   <= 5'(waiting_q + QC'(1));
      end else begin
        status_q <= vbjs_pkg::ST_QFULL;
      end
    end
    if (cmd_i.scan_step && runnable && better) best_q <= sidx;
    if (cmd_i.lookup) hit_idx_q <= bfind[MW-1:0];
    if (cmd_i.hit_commit) begin
      if (mrefs_q[hit_idx_q] < RefsMax) mrefs_q[hit_idx_q] <= mrefs_q[hit_idx_q] + 5'd1;
      mlast_q[hit_idx_q] <= tick_inc;
      ohit_q <= 1'b1;
    end
    if (cmd_i.place) begin
      mkey_q[place_idx]   <= skey_q[best_q];
      mbytes_q[place_idx] <= smsz_q[best_q];
      mrefs_q[place_idx]  <= 5'd1;
      mlast_q[place_idx]  <= tick_inc;
    end
    if (cmd_i.commit) begin
      active_slot_q <= best_q;
      status_q <= vbjs_pkg::ST_STARTED;
      job_q    <= sid_q[best_q];
      oprio_q  <= sprio_q[best_q];
    end
    if (cmd_i.finish) begin
      if (fin_ok) begin
        if (ffind[MW] && mrefs_q[ffind[MW-1:0]] != 5'd0) begin
          mrefs_q[ffind[MW-1:0]] <= mrefs_q[ffind[MW-1:0]] - 5'd1;
          mlast_q[ffind[MW-1:0]] <= tick_inc;
        end
      end else begin
        status_q <= vbjs_pkg::ST_BADDONE;
      end
    end
  end

  assign status_o = status_q;
  assign job_o    = job_q;
  assign prio_o   = oprio_q;
  assign hit_o    = ohit_q;
  assign pos_o    = pos_q;
  assign count_o  = 4'(cnt_q);

endmodule

// ===== hdl/vram_budget_job_scheduler.sv =====
// Top level of the accelerator job scheduler.
// Depends on vbjs_pkg, vbjs_ctrl and vbjs_dp.
//
// Usage:
// Job requests arrive on the s_axis channel; tdata packs op, job_priority,
// model_key, model_size, job_size, preview_size and job_tag. Each request
// yields exactly one result transfer on m_axis. Budgets are set through the
// cfg channel (index 0 total, 1 model cache, 2 generation, 3 preview,
// 4 reserve); the user must write them only while no request is in flight,
// as the block itself does not enforce it. Enqueue, complete and a busy
// start pass through decode, a pass over the residency slots to count
// occupied slots, and output. A granted start adds a scan of one queue entry
// per cycle, a pick and a model lookup, then a commit; on a miss it first
// evicts LRU models as needed and places the model.
// One request is processed at a time; s_axis_tready is high only when the
// controller is idle. A stalled m_axis holds its result until the transfer.
// Reset clears the valid bits, budgets and pool counters at once; no clearing
// pass is needed.
module vram_budget_job_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned MODEL_SLOTS = 8,
  parameter int unsigned KEY_BITS    = 16,
  parameter int unsigned SPACE_BITS  = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op, job_priority, model_key, model_size, job_size, preview_size, job_tag
  input  logic [((4+KEY_BITS+3*SPACE_BITS+32+7)/8)*8-1:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status, granted_job, granted_priority, model hit flag, waiting count,
  // free_space, occupied model slots
  output logic [((47+SPACE_BITS+7)/8)*8-1:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [SPACE_BITS-1:0] cfg_data_i
);

  localparam int unsigned KO = 4;
  localparam int unsigned MO = KO + KEY_BITS;
  localparam int unsigned TO = MO + 3 * SPACE_BITS;
  localparam int unsigned OW = ((47+SPACE_BITS+7)/8)*8;

  vbjs_pkg::cmd_t  cmd;
  vbjs_pkg::stat_t stat;
  logic [2:0]            status;
  logic [31:0]           job;
  logic [1:0]            prio;
  logic                  hit;
  logic [4:0]            pos;
  logic [SPACE_BITS-1:0] free;
  logic [3:0]            cnt;

  assign cfg_ready_o = 1'b1;

  // Controller.
  vbjs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath.
  vbjs_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MODEL_SLOTS (MODEL_SLOTS),
    .KEY_BITS    (KEY_BITS),
    .SPACE_BITS  (SPACE_BITS)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i      (cmd),
    .stat_o     (stat),
    .op_i       (s_axis_tdata[1:0]),
    .prio_i     (s_axis_tdata[3:2]),
    .key_i      (s_axis_tdata[MO-1:KO]),
    .msize_i    (s_axis_tdata[MO+SPACE_BITS-1:MO]),
    .jsize_i    (s_axis_tdata[MO+2*SPACE_BITS-1:MO+SPACE_BITS]),
    .psize_i    (s_axis_tdata[TO-1:MO+2*SPACE_BITS]),
    .tag_i      (s_axis_tdata[TO+31:TO]),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_idx_i  (cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .status_o   (status),
    .job_o      (job),
    .prio_o     (prio),
    .hit_o      (hit),
    .pos_o      (pos),
    .free_o     (free),
    .count_o    (cnt)
  );

  // Result packing.
  assign m_axis_tdata = OW'({cnt, free, pos, hit, prio, job, status});

endmodule
